@@ rtl/core/erdf_pkg.sv @@
// Shared types, constants and the CRC-32 byte update for the receive deframer.
`timescale 1ns / 1ps
`default_nettype none
package erdf_pkg;

  // Frame size limit and the count width that holds it
  localparam int MAX_FRAME_BYTES = 2048;
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int LEN_W           = 12;
  localparam int MAC_W           = 48;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [7:0]  SFD_BYTE = 8'hD5;
  localparam logic [MAC_W-1:0] STATION_MAC_RESET = 48'h0001_0203_0405;

  // Kind of work handed from front to back
  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } erdf_kind_t;

  // End-of-frame status codes
  typedef enum logic [2:0] {
    ST_GOOD_OURS  = 3'd0,
    ST_GOOD_OTHER = 3'd1,
    ST_BAD_FCS    = 3'd2,
    ST_PHY_ERR    = 3'd3,
    ST_RUNT       = 3'd4,
    ST_TOO_LONG   = 3'd5
  } erdf_status_t;

  typedef struct packed {
    erdf_kind_t  kind;
    logic [7:0]  data;
    logic        err;
  } erdf_entry_t;

  // Reflected CRC-32 over one byte, LSB first
  function automatic logic [31:0] crc_byte_update(input logic [31:0] c,
                                                  input logic [7:0]  b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/erdf_front.sv @@
// Front end: accepts GMII words, hunts for the delimiter and classifies the rest.
`timescale 1ns / 1ps
`default_nettype none
module erdf_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_rx_byte,
  input  wire logic                 in_fifo_has_word,
  input  wire logic                 in_data_valid,
  input  wire logic                 in_rx_error,
  input  wire logic                 q_full,
  output logic                      q_push,
  output erdf_pkg::erdf_entry_t     q_entry
);
  import erdf_pkg::*;

  logic in_frame_r;
  logic in_frame_nxt;
  logic accept;
  logic ends;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign ends     = !in_fifo_has_word || !in_data_valid;

  // Hand on frame bytes and frame ends; drop words seen while hunting
  always_comb begin
    q_push        = accept && in_frame_r;
    q_entry.kind  = ends ? KIND_END : KIND_DATA;
    q_entry.data  = in_rx_byte;
    q_entry.err   = in_rx_error;
    in_frame_nxt  = in_frame_r;
    if (accept) begin
      if (ends) begin
        in_frame_nxt = 1'b0;
      end else if (!in_frame_r && (in_rx_byte == SFD_BYTE)) begin
        in_frame_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/erdf_queue.sv @@
// Short queue that decouples the classifying front from the frame back end.
`timescale 1ns / 1ps
`default_nettype none
module erdf_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire erdf_pkg::erdf_entry_t push_entry,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       head_valid,
  output erdf_pkg::erdf_entry_t      head_entry
);
  import erdf_pkg::*;

  erdf_entry_t       slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] fill_r;
  logic              do_pop;

  assign full       = (fill_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_entry = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Store incoming entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/erdf_back.sv @@
// Back end: trailer delay, CRC-32, address match, status and the output register.
`timescale 1ns / 1ps
`default_nettype none
module erdf_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [erdf_pkg::MAC_W-1:0]    station_mac,
  input  wire logic                          q_valid,
  input  wire erdf_pkg::erdf_entry_t         q_entry,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_is_status,
  output logic [7:0]                         out_frame_byte,
  output logic [2:0]                         out_frame_status,
  output logic [erdf_pkg::LEN_W-1:0]         out_frame_length
);
  import erdf_pkg::*;

  logic [CNT_W-1:0] count_r,  count_nxt;
  logic [31:0]      crc_r,    crc_nxt;
  logic             match_r,  match_nxt;
  logic [7:0]       delay_r [4];
  logic             out_valid_r, out_valid_nxt;
  logic             is_status_r;
  logic [7:0]       byte_r;
  logic [2:0]       status_r;
  logic [LEN_W-1:0] length_r;

  logic             can_load;
  logic             res_vld;
  logic             res_is_status;
  logic [7:0]       res_byte;
  erdf_status_t     res_status;
  logic [CNT_W-1:0] addr_idx;
  logic [7:0]       want;
  logic [7:0]       leaving;
  logic [31:0]      fcs;

  assign can_load = !out_valid_r || !out_stall;
  assign q_pop    = q_valid && can_load;
  assign leaving  = delay_r[0];
  assign fcs      = {delay_r[3], delay_r[2], delay_r[1], delay_r[0]};
  assign addr_idx = count_r - CNT_W'(4);

  // Station address byte for the current address position, first byte on top
  always_comb begin
    case (addr_idx[2:0])
      3'd0:    want = station_mac[47:40];
      3'd1:    want = station_mac[39:32];
      3'd2:    want = station_mac[31:24];
      3'd3:    want = station_mac[23:16];
      3'd4:    want = station_mac[15:8];
      default: want = station_mac[7:0];
    endcase
  end

  // Work out the next frame state and the result of the head entry
  always_comb begin
    count_nxt     = count_r;
    crc_nxt       = crc_r;
    match_nxt     = match_r;
    res_vld       = 1'b0;
    res_is_status = 1'b0;
    res_byte      = leaving;
    res_status    = ST_GOOD_OURS;
    if (q_pop) begin
      case (q_entry.kind)
        KIND_END: begin
          res_vld       = (count_r != '0);
          res_is_status = 1'b1;
          res_byte      = 8'd0;
          if (q_entry.err) begin
            res_status = ST_PHY_ERR;
          end else if (count_r <= CNT_W'(4)) begin
            res_status = ST_RUNT;
          end else if (~crc_r != fcs) begin
            res_status = ST_BAD_FCS;
          end else if (count_r >= CNT_W'(MAX_FRAME_BYTES)) begin
            res_status = ST_TOO_LONG;
          end else if (match_r && (count_r >= CNT_W'(10))) begin
            res_status = ST_GOOD_OURS;
          end else begin
            res_status = ST_GOOD_OTHER;
          end
          count_nxt = '0;
          crc_nxt   = CRC_INIT;
          match_nxt = 1'b0;
        end
        default: begin
          if (count_r >= CNT_W'(4)) begin
            res_vld = 1'b1;
            if (count_r < CNT_W'(10)) begin
              match_nxt = (addr_idx == '0) ? (leaving == want)
                                           : (match_r && (leaving == want));
            end
            crc_nxt = crc_byte_update(crc_r, leaving);
          end
          if (count_r < CNT_W'(MAX_FRAME_BYTES)) begin
            count_nxt = count_r + 1'b1;
          end
        end
      endcase
    end
  end

  // Load the output register, or empty it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop && res_vld) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      crc_r       <= CRC_INIT;
      match_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      crc_r       <= crc_nxt;
      match_r     <= match_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Shift the trailer delay on each frame byte
  always_ff @(posedge clk) begin
    if (q_pop && (q_entry.kind == KIND_DATA)) begin
      delay_r[0] <= delay_r[1];
      delay_r[1] <= delay_r[2];
      delay_r[2] <= delay_r[3];
      delay_r[3] <= q_entry.data;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (q_pop && res_vld) begin
      is_status_r <= res_is_status;
      byte_r      <= res_byte;
      status_r    <= res_is_status ? res_status : 3'd0;
      length_r    <= res_is_status ? LEN_W'(count_r) : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_status    = is_status_r;
  assign out_frame_byte   = byte_r;
  assign out_frame_status = status_r;
  assign out_frame_length = length_r;

endmodule
`default_nettype wire

@@ rtl/core/ethernet_rx_deframer_fcs_check.sv @@
// Top level of the Ethernet receive deframer with FCS check.
//
//   port group  | dir | handshake          | carries
//   in_*        | in  | in_valid/in_stall  | rx_byte, fifo_has_word, data_valid, rx_error
//   out_*       | out | out_valid/out_stall| is_status, frame_byte, frame_status, frame_length
//   cfg_*       | in  | cfg_valid/cfg_ready| station_mac
//
// One word is taken per clock while in_stall is low; each word yields at most
// one result, which the back end registers in the output register when it takes
// the word. A four-entry queue sits between the classifying front and the CRC
// back end, and one output register follows it.
// Reset is synchronous, active low: it empties the queue and clears frame state.
// out_stall holds the output register; in_stall rises only when the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module ethernet_rx_deframer_fcs_check (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [7:0]                   in_rx_byte,
  input  wire logic                         in_fifo_has_word,
  input  wire logic                         in_data_valid,
  input  wire logic                         in_rx_error,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_is_status,
  output logic [7:0]                        out_frame_byte,
  output logic [2:0]                        out_frame_status,
  output logic [erdf_pkg::LEN_W-1:0]        out_frame_length,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [erdf_pkg::MAC_W-1:0]   cfg_station_mac
);
  import erdf_pkg::*;

  logic [MAC_W-1:0] station_mac_r;
  logic             q_full;
  logic             q_push;
  erdf_entry_t      q_in_entry;
  logic             q_pop;
  logic             q_valid;
  erdf_entry_t      q_head;

  // Station address register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_mac_r <= STATION_MAC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      station_mac_r <= cfg_station_mac;
    end
  end

  erdf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .in_fifo_has_word (in_fifo_has_word),
    .in_data_valid    (in_data_valid),
    .in_rx_error      (in_rx_error),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (q_in_entry)
  );

  erdf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  erdf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .station_mac      (station_mac_r),
    .q_valid          (q_valid),
    .q_entry          (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_status    (out_is_status),
    .out_frame_byte   (out_frame_byte),
    .out_frame_status (out_frame_status),
    .out_frame_length (out_frame_length)
  );

endmodule
`default_nettype wire

@@ tb/ethernet_rx_deframer_fcs_check_tb.sv @@
// Self-checking testbench for the Ethernet receive deframer with FCS check.
`timescale 1ns / 1ps
module ethernet_rx_deframer_fcs_check_tb;
  import erdf_pkg::*;

  // One forwarded byte or one end-of-frame status
  typedef struct packed {
    logic             is_status;
    logic [7:0]       fbyte;
    logic [2:0]       fstatus;
    logic [LEN_W-1:0] flen;
  } rx_result_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_rx_byte;
  logic             in_fifo_has_word;
  logic             in_data_valid;
  logic             in_rx_error;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_is_status;
  logic [7:0]       out_frame_byte;
  logic [2:0]       out_frame_status;
  logic [LEN_W-1:0] out_frame_length;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [MAC_W-1:0] cfg_station_mac;

  // Predictor state
  logic             rx_in_frame;
  int               rx_count;
  logic [31:0]      rx_crc;
  logic [7:0]       rx_delay [4];
  logic             rx_da_match;
  logic [MAC_W-1:0] station_model;

  rx_result_t       pending_results [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int frame_words   = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int mac_writes    = 0;
  int status_seen [6];

  ethernet_rx_deframer_fcs_check DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .in_fifo_has_word (in_fifo_has_word),
    .in_data_valid    (in_data_valid),
    .in_rx_error      (in_rx_error),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_status    (out_is_status),
    .out_frame_byte   (out_frame_byte),
    .out_frame_status (out_frame_status),
    .out_frame_length (out_frame_length),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_station_mac  (cfg_station_mac)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reflected CRC-32, one data bit at a time, LSB first
  function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    logic        fb;
    int          k;
    v = c;
    for (k = 0; k < 8; k++) begin
      fb = v[0] ^ b[k];
      v  = v >> 1;
      if (fb) v = v ^ CRC_POLY;
    end
    return v;
  endfunction

  function automatic void clear_frame_state();
    rx_in_frame = 1'b0;
    rx_count    = 0;
    rx_crc      = CRC_INIT;
    rx_da_match = 1'b0;
  endfunction

  // Advance the predictor by one accepted word and queue any result it causes
  function automatic void deframe_word(input logic [7:0] b, input logic p, input logic v,
                                       input logic e);
    rx_result_t   r;
    erdf_status_t st;
    logic [31:0]  fcs;
    logic [7:0]   leaving;
    logic [7:0]   want;
    int           idx;
    if (rx_in_frame || !p || !v) frame_words++;
    // Frame end: report only if bytes followed the delimiter
    if (!p || !v) begin
      if (rx_count != 0) begin
        if (e) st = ST_PHY_ERR;
        else if (rx_count <= 4) st = ST_RUNT;
        else begin
          fcs = {rx_delay[3], rx_delay[2], rx_delay[1], rx_delay[0]};
          if (~rx_crc != fcs) st = ST_BAD_FCS;
          else if (rx_count >= MAX_FRAME_BYTES) st = ST_TOO_LONG;
          else if (rx_da_match && rx_count >= 10) st = ST_GOOD_OURS;
          else st = ST_GOOD_OTHER;
        end
        r.is_status = 1'b1;
        r.fbyte     = 8'd0;
        r.fstatus   = st;
        r.flen      = rx_count[LEN_W-1:0];
        pending_results.push_back(r);
      end
      clear_frame_state();
      return;
    end
    // Hunt for the start delimiter
    if (!rx_in_frame) begin
      if (b == SFD_BYTE) rx_in_frame = 1'b1;
      return;
    end
    // Forward the byte leaving the delay line
    if (rx_count >= 4) begin
      leaving = rx_delay[0];
      idx     = rx_count - 4;
      if (idx < 6) begin
        want        = station_model[8*(5-idx) +: 8];
        rx_da_match = (idx == 0) ? (leaving == want) : (rx_da_match && (leaving == want));
      end
      rx_crc      = crc32_next(rx_crc, leaving);
      r.is_status = 1'b0;
      r.fbyte     = leaving;
      r.fstatus   = 3'd0;
      r.flen      = '0;
      pending_results.push_back(r);
    end
    rx_delay[0] = rx_delay[1];
    rx_delay[1] = rx_delay[2];
    rx_delay[2] = rx_delay[3];
    rx_delay[3] = b;
    if (rx_count < MAX_FRAME_BYTES) rx_count++;
  endfunction

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    rx_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status=%0b byte=%02h code=%0d len=%0d",
                   out_is_status, out_frame_byte, out_frame_status, out_frame_length);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.is_status !== out_is_status || exp_r.fbyte !== out_frame_byte ||
            exp_r.fstatus !== out_frame_status || exp_r.flen !== out_frame_length) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0b/%02h/%0d/%0d got %0b/%02h/%0d/%0d",
                     exp_r.is_status, exp_r.fbyte, exp_r.fstatus, exp_r.flen,
                     out_is_status, out_frame_byte, out_frame_status, out_frame_length);
        end
        if (exp_r.is_status && exp_r.fstatus < 6) status_seen[exp_r.fstatus]++;
      end
    end
  end

  // Drive one word and hold it until the transfer
  task automatic send_word(input logic [7:0] b, input logic p, input logic v, input logic e);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_rx_byte       <= b;
    in_fifo_has_word <= p;
    in_data_valid    <= v;
    in_rx_error      <= e;
    do @(posedge clk); while (in_stall);
    deframe_word(b, p, v, e);
  endtask

  // Close a frame by an empty FIFO, a dropped data valid, or both
  task automatic send_end(input logic e);
    int k;
    k = $urandom_range(2);
    send_word(8'($urandom_range(255)), (k == 1), (k == 0), e);
  endtask

  // Well-formed frame: preamble, delimiter, body, FCS (optionally corrupted), end
  // fill: 0 random body, 1 all zero, 2 all ones
  task automatic send_frame(input int body_len, input bit ours, input bit corrupt,
                            input bit phy_err, input int fill);
    logic [31:0] crc;
    logic [7:0]  b;
    int          i;
    int          pre;
    pre = $urandom_range(7);
    for (i = 0; i < pre; i++) send_word(8'h55, 1'b1, 1'b1, 1'($urandom_range(1)));
    send_word(SFD_BYTE, 1'b1, 1'b1, 1'($urandom_range(1)));
    crc = CRC_INIT;
    for (i = 0; i < body_len; i++) begin
      if (ours && i < 6) b = station_model[8*(5-i) +: 8];
      else if (fill == 1) b = 8'h00;
      else if (fill == 2) b = 8'hFF;
      else b = 8'($urandom_range(255));
      crc = crc32_next(crc, b);
      send_word(b, 1'b1, 1'b1, 1'($urandom_range(1)));
    end
    crc = ~crc;
    if (corrupt) crc = crc ^ (32'd1 << $urandom_range(31));
    for (i = 0; i < 4; i++) send_word(crc[8*i +: 8], 1'b1, 1'b1, 1'($urandom_range(1)));
    send_end(phy_err);
  endtask

  // Delimiter, n random bytes, end: runts and cut-off frames
  task automatic send_raw_frame(input int n, input bit phy_err);
    int i;
    send_word(SFD_BYTE, 1'b1, 1'b1, 1'($urandom_range(1)));
    for (i = 0; i < n; i++)
      send_word(8'($urandom_range(255)), 1'b1, 1'b1, 1'($urandom_range(1)));
    send_end(phy_err);
  endtask

  // Random words with random control bits
  task automatic send_noise(input int n);
    int i;
    for (i = 0; i < n; i++)
      send_word(8'($urandom_range(255)), ($urandom_range(9) != 0), ($urandom_range(9) != 0),
                1'($urandom_range(1)));
  endtask

  // Drop valid and let the block drain before touching the register
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_station_mac(input logic [MAC_W-1:0] mac);
    wait_quiet();
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_station_mac <= mac;
    do @(posedge clk); while (!cfg_ready);
    station_model = mac;
    mac_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Ending words with no frame bytes give no result
  task automatic test_empty_ends();
    send_end(1'b0);
    send_end(1'b1);
    send_raw_frame(0, 1'b0);
    send_raw_frame(0, 1'b1);
  endtask

  // Four bytes or fewer; PHY error outranks runt
  task automatic test_runts();
    int n;
    for (n = 1; n <= 4; n++) send_raw_frame(n, 1'b0);
    send_raw_frame(2, 1'b1);
  endtask

  // Address match, short address and byte extremes
  task automatic test_good_frames();
    send_frame(6, 1'b1, 1'b0, 1'b0, 0);
    send_frame(5, 1'b1, 1'b0, 1'b0, 0);
    send_frame(2, 1'b1, 1'b0, 1'b0, 0);
    send_frame(1, 1'b0, 1'b0, 1'b0, 0);
    send_frame(12, 1'b0, 1'b0, 1'b0, 1);
    send_frame(12, 1'b1, 1'b0, 1'b0, 2);
  endtask

  task automatic test_fcs_and_phy_errors();
    send_frame(10, 1'b1, 1'b1, 1'b0, 0);
    send_frame(10, 1'b1, 1'b0, 1'b1, 0);
    send_frame(10, 1'b0, 1'b1, 1'b1, 0);
  endtask

  // Mostly well-formed frames with random content, some cut-off frames and noise
  task automatic test_random_traffic(input logic [MAC_W-1:0] mac, input int send_pct,
                                     input int recv_pct, input int n_words);
    int stop_at;
    int pick;
    int body;
    write_station_mac(mac);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    stop_at       = frame_words + n_words;
    while (frame_words < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        body = ($urandom_range(3) == 0) ? $urandom_range(21, 80) : $urandom_range(1, 20);
        send_frame(body, 1'($urandom_range(1)), ($urandom_range(99) < 15),
                   ($urandom_range(99) < 10),
                   ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0);
      end else if (pick < 88) begin
        send_raw_frame($urandom_range(12), ($urandom_range(99) < 10));
      end else begin
        send_noise($urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    in_valid         = 1'b0;
    in_rx_byte       = 8'd0;
    in_fifo_has_word = 1'b0;
    in_data_valid    = 1'b0;
    in_rx_error      = 1'b0;
    cfg_valid        = 1'b0;
    cfg_station_mac  = '0;
    rst_n            = 1'b0;
    station_model    = STATION_MAC_RESET;
    rx_delay         = '{default: 8'h00};
    clear_frame_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed checks run at the reset address, no idling
    test_empty_ends();
    test_runts();
    test_good_frames();
    test_fcs_and_phy_errors();

    test_random_traffic(48'hFFFF_FFFF_FFFF, 35, 57, 280);
    test_random_traffic(48'h0000_0000_0000, 57, 35, 280);
    test_random_traffic(48'({$urandom, $urandom}), 0, 0, 280);

    wait_quiet();
    $display("summary: %0d frame words, %0d results checked, %0d address writes, %0d mismatches",
             frame_words, results_seen, mac_writes, mismatches);
    $display("summary: ours %0d, other %0d, bad fcs %0d, phy err %0d, runt %0d, too long %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             status_seen[5]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
